[sv/bgpc_pkg.sv]
// shared types and constants for the battery guarded pump controller
// depends on nothing; imported by every module of the block

package bgpc_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // modes
   localparam logic [2:0] MODE_BOOT  = 3'd0;
   localparam logic [2:0] MODE_IDLE  = 3'd1;
   localparam logic [2:0] MODE_PUMP  = 3'd2;
   localparam logic [2:0] MODE_LOWB  = 3'd3;
   localparam logic [2:0] MODE_SLEEP = 3'd4;

   // event kinds
   localparam logic [2:0] FUNC_TICK  = 3'd0;
   localparam logic [2:0] FUNC_BOOT  = 3'd1;
   localparam logic [2:0] FUNC_START = 3'd2;
   localparam logic [2:0] FUNC_STOP  = 3'd3;
   localparam logic [2:0] FUNC_SLEEP = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BATTERY_OK   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BATTERY_LOW  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BATTERY_CRIT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DAYLIGHT     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RUN      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_WATCHDOG     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_TIMEOUT = 3'd7;

   // register reset values
   localparam logic [15:0] RST_BATTERY_OK   = 16'd12800;
   localparam logic [15:0] RST_BATTERY_LOW  = 16'd12000;
   localparam logic [15:0] RST_BATTERY_CRIT = 16'd11800;
   localparam logic [15:0] RST_DAYLIGHT     = 16'd5000;
   localparam logic [31:0] RST_MAX_RUN      = 32'd7200000;
   localparam logic [15:0] RST_DEBOUNCE     = 16'd30;
   localparam logic [31:0] RST_WATCHDOG     = 32'd600000;
   localparam logic [31:0] RST_IDLE_TIMEOUT = 32'd30000;

   // heartbeat: (now / 500) = ((now >> 2) / 125), taken by reciprocal multiply
   localparam int          LED_QUARTER_W = 30;
   localparam int          LED_RECIP_W   = 31;
   localparam int          LED_SHIFT     = 37;
   localparam logic [LED_RECIP_W-1:0] LED_RECIP = 31'd1099511628;

   typedef struct packed {
      logic [15:0] battery_ok_mv;
      logic [15:0] battery_low_mv;
      logic [15:0] battery_critical_mv;
      logic [15:0] daylight_mv;
      logic [31:0] run_limit_ms;
      logic [15:0] debounce_ms;
      logic [31:0] watchdog_ms;
      logic [31:0] idle_timeout_ms;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [31:0] now_ms;
      logic [15:0] battery_mv;
      logic [15:0] solar_mv;
      logic        button_level;
      logic        woke_by_button;
   } req_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic        pump_on;
      logic        sleep_request;
      logic        led_on;
      logic [31:0] run_ms;
      logic        start_refused;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  mode_state;
      logic [31:0] pump_start_time;
      logic [31:0] last_command_time;
      logic [31:0] button_edge_time;
      logic        button_last_level;
      logic        button_stable_level;
   } state_type;

endpackage

[sv/bgpc_if.sv]
// valid/ready channel interfaces for event items and result items
// no dependencies

interface bgpc_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  func;
   logic [31:0] now_ms;
   logic [15:0] battery_mv;
   logic [15:0] solar_mv;
   logic        button_level;
   logic        woke_by_button;

   modport source (output valid, func, now_ms, battery_mv, solar_mv, button_level,
                   woke_by_button, input ready);
   modport sink (input valid, func, now_ms, battery_mv, solar_mv, button_level,
                 woke_by_button, output ready);
endinterface

interface bgpc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic        pump_on;
   logic        sleep_request;
   logic        led_on;
   logic [31:0] run_ms;
   logic        start_refused;

   modport source (output valid, mode, pump_on, sleep_request, led_on, run_ms,
                   start_refused, input ready);
   modport sink (input valid, mode, pump_on, sleep_request, led_on, run_ms,
                 start_refused, output ready);
endinterface

[sv/battery_guarded_pump_controller.sv]
// top level of the battery guarded pump controller
// depends on bgpc_pkg, bgpc_if, bgpc_csr and bgpc_core
//
// Each event item gives exactly one result item. The block takes one item per
// clock while the result side does not stall: the item lands in an input
// register, then the event step runs in one pass of compare logic and a
// single reciprocal multiply for the heartbeat and loads the result into an
// output register that holds it while the result side stalls. The user must
// write configuration registers through csr_we/csr_index/csr_wdata only
// while no item is in flight; the block itself does not enforce this.

module battery_guarded_pump_controller
   import bgpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   bgpc_req_if.sink              req_if,
   bgpc_rsp_if.source            rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg;
   req_type req_in, req_ff;
   rsp_type rsp_in, rsp_ff;
   logic    in_valid_ff, in_valid_in;
   logic    out_valid_ff, out_valid_in;
   logic    advance;

   bgpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bgpc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .req     (req_ff),
      .cfg     (cfg),
      .rsp     (rsp_in)
   );

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;

   always_comb begin
      req_in.func           = req_if.func;
      req_in.now_ms         = req_if.now_ms;
      req_in.battery_mv     = req_if.battery_mv;
      req_in.solar_mv       = req_if.solar_mv;
      req_in.button_level   = req_if.button_level;
      req_in.woke_by_button = req_if.woke_by_button;
      in_valid_in  = (req_if.valid && req_if.ready) || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         req_ff <= req_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.mode          = rsp_ff.mode;
   assign rsp_if.pump_on       = rsp_ff.pump_on;
   assign rsp_if.sleep_request = rsp_ff.sleep_request;
   assign rsp_if.led_on        = rsp_ff.led_on;
   assign rsp_if.run_ms        = rsp_ff.run_ms;
   assign rsp_if.start_refused = rsp_ff.start_refused;

endmodule

[sv/bgpc_csr.sv]
// configuration register file, written through a plain write port
// depends on bgpc_pkg

module bgpc_csr
   import bgpc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_BATTERY_OK:   cfg_in.battery_ok_mv       = csr_wdata[15:0];
            CSR_BATTERY_LOW:  cfg_in.battery_low_mv      = csr_wdata[15:0];
            CSR_BATTERY_CRIT: cfg_in.battery_critical_mv = csr_wdata[15:0];
            CSR_DAYLIGHT:     cfg_in.daylight_mv         = csr_wdata[15:0];
            CSR_MAX_RUN:      cfg_in.run_limit_ms        = csr_wdata;
            CSR_DEBOUNCE:     cfg_in.debounce_ms         = csr_wdata[15:0];
            CSR_WATCHDOG:     cfg_in.watchdog_ms         = csr_wdata;
            CSR_IDLE_TIMEOUT: cfg_in.idle_timeout_ms     = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.battery_ok_mv       <= RST_BATTERY_OK;
         cfg_ff.battery_low_mv      <= RST_BATTERY_LOW;
         cfg_ff.battery_critical_mv <= RST_BATTERY_CRIT;
         cfg_ff.daylight_mv         <= RST_DAYLIGHT;
         cfg_ff.run_limit_ms        <= RST_MAX_RUN;
         cfg_ff.debounce_ms         <= RST_DEBOUNCE;
         cfg_ff.watchdog_ms         <= RST_WATCHDOG;
         cfg_ff.idle_timeout_ms     <= RST_IDLE_TIMEOUT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[sv/bgpc_core.sv]
// controller state and single-pass event step logic
// depends on bgpc_pkg

module bgpc_core
   import bgpc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step_en,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type rsp
);

   state_type st_ff, st_in;
   logic      sleep_req;
   logic      refused;
   logic      press;
   logic [31:0] age;
   logic [LED_QUARTER_W+LED_RECIP_W-1:0] led_prod;

   always_comb begin
      st_in     = st_ff;
      sleep_req = 1'b0;
      refused   = 1'b0;
      press     = 1'b0;
      age       = 32'd0;
      case (req.func)
         FUNC_BOOT: begin
            st_in.button_last_level   = 1'b1;
            st_in.button_stable_level = 1'b1;
            st_in.button_edge_time    = req.now_ms;
            st_in.last_command_time   = req.now_ms;
            st_in.pump_start_time     = 32'd0;
            if (req.battery_mv < cfg.battery_low_mv) begin
               st_in.mode_state = MODE_LOWB;
               sleep_req        = 1'b1;
            end else if (req.woke_by_button || req.solar_mv >= cfg.daylight_mv) begin
               st_in.mode_state      = MODE_PUMP;
               st_in.pump_start_time = req.now_ms;
            end else begin
               st_in.mode_state = MODE_IDLE;
            end
         end
         FUNC_START: begin
            st_in.last_command_time = req.now_ms;
            if (st_ff.mode_state == MODE_IDLE && req.battery_mv >= cfg.battery_ok_mv) begin
               st_in.mode_state      = MODE_PUMP;
               st_in.pump_start_time = req.now_ms;
            end else begin
               refused = 1'b1;
            end
         end
         FUNC_STOP: begin
            st_in.last_command_time = req.now_ms;
            if (st_ff.mode_state == MODE_PUMP) begin
               st_in.mode_state = MODE_IDLE;
            end
         end
         FUNC_SLEEP: begin
            st_in.mode_state = MODE_SLEEP;
            sleep_req        = 1'b1;
         end
         FUNC_TICK: begin
            if (st_ff.mode_state == MODE_IDLE || st_ff.mode_state == MODE_PUMP) begin
               // button debounce
               if (req.button_level != st_ff.button_last_level) begin
                  st_in.button_edge_time  = req.now_ms;
                  st_in.button_last_level = req.button_level;
               end
               age = req.now_ms - st_in.button_edge_time;
               if (age > {16'd0, cfg.debounce_ms} &&
                   req.button_level != st_ff.button_stable_level) begin
                  st_in.button_stable_level = req.button_level;
                  press = !req.button_level;
               end
               // press toggles idle and pumping
               if (press) begin
                  st_in.last_command_time = req.now_ms;
                  if (st_in.mode_state == MODE_PUMP) begin
                     st_in.mode_state = MODE_IDLE;
                  end else if (req.battery_mv >= cfg.battery_ok_mv) begin
                     st_in.mode_state      = MODE_PUMP;
                     st_in.pump_start_time = req.now_ms;
                  end else begin
                     refused = 1'b1;
                  end
               end
               // pumping guards
               if (st_in.mode_state == MODE_PUMP) begin
                  if (req.battery_mv < cfg.battery_critical_mv) begin
                     st_in.mode_state = MODE_LOWB;
                     sleep_req        = 1'b1;
                  end else begin
                     if (req.now_ms - st_in.pump_start_time >= cfg.run_limit_ms) begin
                        st_in.mode_state = MODE_IDLE;
                     end
                     if (req.now_ms - st_in.last_command_time >= cfg.watchdog_ms) begin
                        st_in.last_command_time = req.now_ms;
                     end
                  end
               end
               // idle timeout
               if (st_in.mode_state == MODE_IDLE &&
                   req.now_ms - st_in.last_command_time > cfg.idle_timeout_ms) begin
                  st_in.mode_state = MODE_SLEEP;
                  sleep_req        = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   // parity of now / 500
   assign led_prod = {{LED_RECIP_W{1'b0}}, req.now_ms[31:2]} *
                     {{LED_QUARTER_W{1'b0}}, LED_RECIP};

   always_comb begin
      rsp.mode          = st_in.mode_state;
      rsp.pump_on       = (st_in.mode_state == MODE_PUMP);
      rsp.sleep_request = sleep_req;
      rsp.led_on        = (st_in.mode_state == MODE_PUMP) && led_prod[LED_SHIFT];
      rsp.run_ms        = (st_in.mode_state == MODE_PUMP) ?
                          (req.now_ms - st_in.pump_start_time) : 32'd0;
      rsp.start_refused = refused;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.mode_state          <= MODE_BOOT;
         st_ff.pump_start_time     <= 32'd0;
         st_ff.last_command_time   <= 32'd0;
         st_ff.button_edge_time    <= 32'd0;
         st_ff.button_last_level   <= 1'b1;
         st_ff.button_stable_level <= 1'b1;
      end else if (step_en) begin
         st_ff <= st_in;
      end
   end

endmodule
